// ===== rtl/core/gld_pkg.sv =====
// Shared constants, codes and types for the GIF LZW decoder.
// Depends on nothing; the decoder unit and gld_csr refer to it by scoped names.
package gld_pkg;

   localparam int MAX_CODE_BITS = 12;
   localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
   localparam int STACK_DEPTH   = 4096;
   localparam int STACK_AW      = $clog2(STACK_DEPTH);
   localparam int CNT_W         = STACK_AW + 1;
   localparam int CODE_W        = MAX_CODE_BITS;
   localparam int NFC_W         = MAX_CODE_BITS + 1;
   localparam int RESV_W        = 32;
   localparam int HELD_W        = 6;
   localparam int RESV_HOLD_MAX = 24;
   localparam int MIN_CODE_RESET = 8;
   localparam int MIN_ROOT      = 2;
   localparam int MAX_ROOT      = 8;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_PULL  = 2'd1,
      MODE_START = 2'd2,
      MODE_BAD   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_SYMBOL   = 3'd0,
      STAT_NEED     = 3'd1,
      STAT_END      = 3'd2,
      STAT_ERROR    = 3'd3,
      STAT_ACCEPTED = 3'd4,
      STAT_FULL     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_DECODE,
      S_WALK,
      S_WALK_DATA
   } state_type;

   localparam logic [0:0] REG_MIN_CODE_SIZE = 1'b0;

endpackage

// ===== rtl/core/gif_lzw_decoder_unit.sv =====
// Top level of the GIF LZW decoder: byte unpacking, code decoding, chain walk.
// Depends on gld_pkg, gld_ram and gld_csr.
//
//   port group | dir | contents
//   req_*      | in  | one command beat: push byte, pull symbol or start image
//   rsp_*      | out | one result beat per command: status and symbol
//   csr_*      | i/o | register access to min_code_size
//
// Push, start and an undefined command are answered from S_IDLE; a pull served from the
// string stack passes through S_POP for the registered stack read. A pull that decodes
// goes from S_IDLE to S_DECODE, which takes one code per visit (clear codes repeat it),
// then alternates S_WALK and S_WALK_DATA for each chain link read from the prefix and
// suffix RAMs, and ends the walk with the root symbol in S_WALK.
// Reset is synchronous and loads the state of a fresh image; the stores need
// no clearing pass. One command is in flight at a time, and a waiting result
// beat holds off the next command until it is taken; both may happen at the
// same edge.
module gif_lzw_decoder_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic [1:0]                     req_tuser,   // [1:0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] symbol
   output logic [2:0]                     rsp_tuser,   // [2:0] status
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [gld_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gld_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gld_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int AW = gld_pkg::STACK_AW;
   localparam int TW = gld_pkg::MAX_CODE_BITS;

   logic [3:0] min_code_size;

   gld_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .min_code_size (min_code_size)
   );

   gld_pkg::state_type              state_ff, state_in;
   logic [3:0]                      root_ff, root_in;
   logic [gld_pkg::RESV_W-1:0]      resv_ff, resv_in;
   logic [gld_pkg::HELD_W-1:0]      held_ff, held_in;
   logic [7:0]                      blk_ff, blk_in;
   logic                            dfin_ff, dfin_in;
   logic [3:0]                      cw_ff, cw_in;
   logic [gld_pkg::NFC_W-1:0]       nfc_ff, nfc_in;
   logic [gld_pkg::NFC_W-1:0]       wl_ff, wl_in;
   logic [7:0]                      first_ff, first_in;
   logic [gld_pkg::CODE_W-1:0]      prev_ff, prev_in;
   logic                            expf_ff, expf_in;
   logic                            ended_ff, ended_in;
   logic [gld_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [gld_pkg::CODE_W-1:0]      code_ff, code_in;
   logic [gld_pkg::CODE_W-1:0]      cur_ff, cur_in;
   logic                            ovalid_ff, ovalid_in;
   logic [2:0]                      ostat_ff, ostat_in;
   logic [7:0]                      osym_ff, osym_in;

   logic                            tab_we;
   logic [TW-1:0]                   tab_raddr;
   logic [gld_pkg::CODE_W-1:0]      pfx_rdata;
   logic [7:0]                      sfx_rdata;
   logic                            stk_we;
   logic [7:0]                      stk_wdata;
   logic [7:0]                      stk_rdata;
   logic [AW-1:0]                   stk_raddr;
   logic [gld_pkg::CNT_W-1:0]       cnt_dec;

   gld_ram #(.WIDTH(gld_pkg::CODE_W), .DEPTH(gld_pkg::TABLE_SIZE)) u_prefix (
      .clock (clock), .we (tab_we), .waddr (nfc_ff[TW-1:0]), .wdata (prev_ff),
      .raddr (tab_raddr), .rdata (pfx_rdata)
   );

   gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::TABLE_SIZE)) u_suffix (
      .clock (clock), .we (tab_we), .waddr (nfc_ff[TW-1:0]), .wdata (cur_ff[7:0]),
      .raddr (tab_raddr), .rdata (sfx_rdata)
   );

   gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::STACK_DEPTH)) u_stack (
      .clock (clock), .we (stk_we), .waddr (cnt_ff[AW-1:0]), .wdata (stk_wdata),
      .raddr (stk_raddr), .rdata (stk_rdata)
   );

   assign cnt_dec   = cnt_ff - 1'b1;
   assign stk_raddr = cnt_dec[AW-1:0];
   assign tab_raddr = cur_ff[TW-1:0];

   logic                       accept;
   gld_pkg::mode_type          mode;
   logic [7:0]                 dbyte;
   logic [3:0]                 root_sat;
   logic [gld_pkg::NFC_W-1:0]  clear_code;
   logic [gld_pkg::NFC_W-1:0]  clear_new;
   logic [gld_pkg::RESV_W-1:0] code_mask;
   logic [gld_pkg::CODE_W-1:0] code_now;
   logic [gld_pkg::NFC_W-1:0]  code_ext;
   logic [gld_pkg::NFC_W-1:0]  nfc_inc;
   logic                       stk_full;

   assign req_tready = (state_ff == gld_pkg::S_IDLE) && (!ovalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign mode       = gld_pkg::mode_type'(req_tuser);
   assign dbyte      = req_tdata;
   assign clear_code = gld_pkg::NFC_W'(1) << root_ff;
   assign code_mask  = (gld_pkg::RESV_W'(1) << cw_ff) - 1'b1;
   assign code_now   = gld_pkg::CODE_W'(resv_ff & code_mask);
   assign code_ext   = {1'b0, code_now};
   assign nfc_inc    = nfc_ff + 1'b1;
   assign stk_full   = (cnt_ff >= gld_pkg::CNT_W'(gld_pkg::STACK_DEPTH));

   always_comb begin
      if (min_code_size < 4'(gld_pkg::MIN_ROOT)) begin
         root_sat = 4'(gld_pkg::MIN_ROOT);
      end else if (min_code_size > 4'(gld_pkg::MAX_ROOT)) begin
         root_sat = 4'(gld_pkg::MAX_ROOT);
      end else begin
         root_sat = min_code_size;
      end
      clear_new = gld_pkg::NFC_W'(1) << root_sat;
   end

   always_comb begin
      state_in  = state_ff;
      root_in   = root_ff;
      resv_in   = resv_ff;
      held_in   = held_ff;
      blk_in    = blk_ff;
      dfin_in   = dfin_ff;
      cw_in     = cw_ff;
      nfc_in    = nfc_ff;
      wl_in     = wl_ff;
      first_in  = first_ff;
      prev_in   = prev_ff;
      expf_in   = expf_ff;
      ended_in  = ended_ff;
      cnt_in    = cnt_ff;
      code_in   = code_ff;
      cur_in    = cur_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      ostat_in  = ostat_ff;
      osym_in   = osym_ff;
      tab_we    = 1'b0;
      stk_we    = 1'b0;
      stk_wdata = sfx_rdata;

      unique case (state_ff)
         gld_pkg::S_IDLE: begin
            if (accept) begin
               ovalid_in = 1'b1;
               osym_in   = '0;
               unique case (mode)
                  gld_pkg::MODE_PUSH: begin
                     ostat_in = gld_pkg::STAT_ACCEPTED;
                     if (dfin_ff || ended_ff) begin
                        ostat_in = gld_pkg::STAT_ACCEPTED;
                     end else if (blk_ff == 8'd0) begin
                        if (dbyte == 8'd0) begin
                           dfin_in = 1'b1;
                        end else begin
                           blk_in = dbyte;
                        end
                     end else if (held_ff > gld_pkg::HELD_W'(gld_pkg::RESV_HOLD_MAX)) begin
                        ostat_in = gld_pkg::STAT_FULL;
                     end else begin
                        resv_in = resv_ff | ({24'd0, dbyte} << held_ff);
                        held_in = held_ff + gld_pkg::HELD_W'(8);
                        blk_in  = blk_ff - 1'b1;
                     end
                  end
                  gld_pkg::MODE_PULL: begin
                     if (ended_ff) begin
                        ostat_in = gld_pkg::STAT_END;
                     end else if (cnt_ff != '0) begin
                        // Stack read is issued now; S_POP registers the symbol into the result beat.
                        ovalid_in = 1'b0;
                        cnt_in    = cnt_dec;
                        state_in  = gld_pkg::S_POP;
                     end else begin
                        ovalid_in = 1'b0;
                        state_in  = gld_pkg::S_DECODE;
                     end
                  end
                  gld_pkg::MODE_START: begin
                     ostat_in = gld_pkg::STAT_ACCEPTED;
                     root_in  = root_sat;
                     resv_in  = '0;
                     held_in  = '0;
                     blk_in   = '0;
                     dfin_in  = 1'b0;
                     first_in = '0;
                     prev_in  = '0;
                     ended_in = 1'b0;
                     cw_in    = root_sat + 1'b1;
                     nfc_in   = clear_new + gld_pkg::NFC_W'(2);
                     wl_in    = clear_new << 1;
                     cnt_in   = '0;
                     expf_in  = 1'b1;
                  end
                  gld_pkg::MODE_BAD: begin
                     ostat_in = gld_pkg::STAT_ERROR;
                  end
               endcase
            end
         end

         gld_pkg::S_POP: begin
            ovalid_in = 1'b1;
            ostat_in  = gld_pkg::STAT_SYMBOL;
            osym_in   = stk_rdata;
            state_in  = gld_pkg::S_IDLE;
         end

         gld_pkg::S_DECODE: begin
            osym_in = '0;
            if (held_ff < {2'b00, cw_ff}) begin
               ovalid_in = 1'b1;
               state_in  = gld_pkg::S_IDLE;
               if (dfin_ff) begin
                  ended_in = 1'b1;
                  ostat_in = gld_pkg::STAT_END;
               end else begin
                  ostat_in = gld_pkg::STAT_NEED;
               end
            end else begin
               resv_in = resv_ff >> cw_ff;
               held_in = held_ff - {2'b00, cw_ff};
               if (code_ext == clear_code) begin
                  cw_in   = root_ff + 1'b1;
                  nfc_in  = clear_code + gld_pkg::NFC_W'(2);
                  wl_in   = clear_code << 1;
                  cnt_in  = '0;
                  expf_in = 1'b1;
               end else if (code_ext == clear_code + 1'b1) begin
                  ended_in  = 1'b1;
                  ovalid_in = 1'b1;
                  ostat_in  = gld_pkg::STAT_END;
                  state_in  = gld_pkg::S_IDLE;
               end else if (expf_ff) begin
                  ovalid_in = 1'b1;
                  state_in  = gld_pkg::S_IDLE;
                  if (code_ext > clear_code) begin
                     ostat_in = gld_pkg::STAT_ERROR;
                  end else begin
                     expf_in  = 1'b0;
                     first_in = code_now[7:0];
                     prev_in  = code_now;
                     ostat_in = gld_pkg::STAT_SYMBOL;
                     osym_in  = code_now[7:0];
                  end
               end else if (code_ext > nfc_ff) begin
                  ovalid_in = 1'b1;
                  ostat_in  = gld_pkg::STAT_ERROR;
                  state_in  = gld_pkg::S_IDLE;
               end else begin
                  code_in  = code_now;
                  cur_in   = code_now;
                  state_in = gld_pkg::S_WALK;
                  if (code_ext == nfc_ff) begin
                     // KwKwK: the string is the previous one plus its own first symbol.
                     if (stk_full) begin
                        cnt_in    = '0;
                        ovalid_in = 1'b1;
                        ostat_in  = gld_pkg::STAT_ERROR;
                        state_in  = gld_pkg::S_IDLE;
                     end else begin
                        stk_we    = 1'b1;
                        stk_wdata = first_ff;
                        cnt_in    = cnt_ff + 1'b1;
                        cur_in    = prev_ff;
                     end
                  end
               end
            end
         end

         gld_pkg::S_WALK: begin
            if ({1'b0, cur_ff} >= clear_code) begin
               state_in = gld_pkg::S_WALK_DATA;
            end else begin
               ovalid_in = 1'b1;
               state_in  = gld_pkg::S_IDLE;
               osym_in   = '0;
               if (stk_full) begin
                  cnt_in   = '0;
                  ostat_in = gld_pkg::STAT_ERROR;
               end else begin
                  // The root symbol is pushed and popped at once, so it never hits the RAM.
                  first_in = cur_ff[7:0];
                  prev_in  = code_ff;
                  ostat_in = gld_pkg::STAT_SYMBOL;
                  osym_in  = cur_ff[7:0];
                  if (nfc_ff < gld_pkg::NFC_W'(gld_pkg::TABLE_SIZE)) begin
                     tab_we = 1'b1;
                     nfc_in = nfc_inc;
                     if (nfc_inc >= wl_ff && wl_ff < gld_pkg::NFC_W'(gld_pkg::TABLE_SIZE)) begin
                        wl_in = wl_ff << 1;
                        cw_in = cw_ff + 1'b1;
                     end
                  end
               end
            end
         end

         gld_pkg::S_WALK_DATA: begin
            if (stk_full) begin
               cnt_in    = '0;
               ovalid_in = 1'b1;
               ostat_in  = gld_pkg::STAT_ERROR;
               osym_in   = '0;
               state_in  = gld_pkg::S_IDLE;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = sfx_rdata;
               cnt_in    = cnt_ff + 1'b1;
               cur_in    = pfx_rdata;
               state_in  = gld_pkg::S_WALK;
            end
         end

         default: begin
            state_in = gld_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gld_pkg::S_IDLE;
         root_ff   <= 4'(gld_pkg::MIN_CODE_RESET);
         resv_ff   <= '0;
         held_ff   <= '0;
         blk_ff    <= '0;
         dfin_ff   <= 1'b0;
         cw_ff     <= 4'(gld_pkg::MIN_CODE_RESET + 1);
         nfc_ff    <= gld_pkg::NFC_W'((1 << gld_pkg::MIN_CODE_RESET) + 2);
         wl_ff     <= gld_pkg::NFC_W'(2 << gld_pkg::MIN_CODE_RESET);
         first_ff  <= '0;
         prev_ff   <= '0;
         expf_ff   <= 1'b1;
         ended_ff  <= 1'b0;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         root_ff   <= root_in;
         resv_ff   <= resv_in;
         held_ff   <= held_in;
         blk_ff    <= blk_in;
         dfin_ff   <= dfin_in;
         cw_ff     <= cw_in;
         nfc_ff    <= nfc_in;
         wl_ff     <= wl_in;
         first_ff  <= first_in;
         prev_ff   <= prev_in;
         expf_ff   <= expf_in;
         ended_ff  <= ended_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
      code_ff  <= code_in;
      cur_ff   <= cur_in;
      ostat_ff <= ostat_in;
      osym_ff  <= osym_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = ostat_ff;
   assign rsp_tdata  = osym_ff;

endmodule

// ===== rtl/core/gld_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; used for the prefix, suffix and string stack stores.
module gld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/gld_csr.sv =====
// Configuration register block holding the LZW minimum code size.
// Depends on gld_pkg.
module gld_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gld_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gld_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gld_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [3:0]                        min_code_size
);

   logic [3:0] min_ff;
   logic [3:0] min_in;
   logic       hit;

   assign hit        = (csr_paddr[2:2] == gld_pkg::REG_MIN_CODE_SIZE);
   assign csr_pready = 1'b1;

   always_comb begin
      min_in = min_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         min_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 4'(gld_pkg::MIN_CODE_RESET);
      end else begin
         min_ff <= min_in;
      end
   end

   assign csr_prdata    = hit ? {28'd0, min_ff} : '0;
   assign min_code_size = min_ff;

endmodule

// ===== verif/tb_gif_lzw_decoder_unit.sv =====
// Self-checking testbench for gif_lzw_decoder_unit: generates framed LZW code streams,
// predicts every result beat in a cycle-free model and compares it at the output.
// Depends on gld_pkg and the RTL under rtl/core.
module tb_gif_lzw_decoder_unit;
   import gld_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      mode_type   mode;
      logic [7:0] data;
      bit         hold;
   } cmd_beat_type;

   typedef struct {
      status_type status;
      logic [7:0] symbol;
   } result_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic [1:0]            req_tuser;   // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [7:0] symbol
   logic [2:0]            rsp_tuser;   // [2:0] status
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gif_lzw_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   cmd_beat_type    cmd_queue[$];
   result_beat_type expected_results[$];
   int              idle_pct;
   int              stall_pct;
   bit              cmd_taken;
   int              cycle_count;
   int              mismatches;
   int              cmds_sent;
   int              results_seen;
   int              symbols_seen;
   int              images_built;

   // Decoder model state.
   logic [3:0]  cfg_min_size;
   int unsigned m_root;
   logic [31:0] m_resv;
   int unsigned m_held;
   int unsigned m_block_left;
   bit          m_finished;
   int unsigned m_width;
   int unsigned m_next_code;
   int unsigned m_width_limit;
   int unsigned m_first_sym;
   int unsigned m_prev_code;
   bit          m_expect_first;
   bit          m_ended;
   bit [11:0]   m_prefix[0:TABLE_SIZE-1];
   bit [7:0]    m_suffix[0:TABLE_SIZE-1];
   bit [7:0]    m_stack[0:STACK_DEPTH-1];
   int unsigned m_stack_count;

   function automatic void model_clear_table();
      m_width       = m_root + 1;
      m_next_code   = (1 << m_root) + 2;
      m_width_limit = 2 * (1 << m_root);
      m_stack_count = 0;
      m_expect_first = 1'b1;
   endfunction

   function automatic void model_start();
      m_root = cfg_min_size;
      if (m_root < MIN_ROOT) m_root = MIN_ROOT;
      if (m_root > MAX_ROOT) m_root = MAX_ROOT;
      m_resv       = '0;
      m_held       = 0;
      m_block_left = 0;
      m_finished   = 1'b0;
      m_first_sym  = 0;
      m_prev_code  = 0;
      m_ended      = 1'b0;
      model_clear_table();
   endfunction

   function automatic bit stack_push(bit [7:0] s);
      if (m_stack_count >= STACK_DEPTH) return 1'b0;
      m_stack[m_stack_count] = s;
      m_stack_count++;
      return 1'b1;
   endfunction

   function automatic status_type model_push(logic [7:0] b);
      if (m_finished || m_ended) return STAT_ACCEPTED;
      if (m_block_left == 0) begin
         if (b == 8'd0) m_finished = 1'b1;
         else m_block_left = b;
         return STAT_ACCEPTED;
      end
      if (m_held > RESV_HOLD_MAX) return STAT_FULL;
      m_resv = m_resv | (32'(b) << m_held);
      m_held += 8;
      m_block_left--;
      return STAT_ACCEPTED;
   endfunction

   function automatic status_type model_pull(output logic [7:0] sym);
      int unsigned clr;
      int unsigned code;
      int unsigned cur;
      clr = 1 << m_root;
      sym = 8'd0;
      if (m_ended) return STAT_END;
      if (m_stack_count > 0) begin
         m_stack_count--;
         sym = m_stack[m_stack_count];
         return STAT_SYMBOL;
      end
      while (1) begin
         if (m_held < m_width) begin
            if (m_finished) begin
               m_ended = 1'b1;
               return STAT_END;
            end
            return STAT_NEED;
         end
         code = m_resv & ((32'd1 << m_width) - 1);
         m_resv = m_resv >> m_width;
         m_held -= m_width;
         if (code == clr) begin
            model_clear_table();
            continue;
         end
         if (code == clr + 1) begin
            m_ended = 1'b1;
            return STAT_END;
         end
         if (m_expect_first) begin
            if (code > clr) return STAT_ERROR;
            m_expect_first = 1'b0;
            m_first_sym = code;
            m_prev_code = code;
            sym = 8'(code);
            return STAT_SYMBOL;
         end
         if (code > m_next_code) return STAT_ERROR;
         cur = code;
         // A code one past the table is the string of the previous code plus its first symbol.
         if (code == m_next_code) begin
            if (!stack_push(8'(m_first_sym))) begin
               m_stack_count = 0;
               return STAT_ERROR;
            end
            cur = m_prev_code;
         end
         while (cur >= clr) begin
            if (!stack_push(m_suffix[cur % TABLE_SIZE])) begin
               m_stack_count = 0;
               return STAT_ERROR;
            end
            cur = m_prefix[cur % TABLE_SIZE];
         end
         if (!stack_push(8'(cur))) begin
            m_stack_count = 0;
            return STAT_ERROR;
         end
         m_first_sym = cur & 255;
         if (m_next_code < TABLE_SIZE) begin
            m_prefix[m_next_code] = 12'(m_prev_code);
            m_suffix[m_next_code] = 8'(m_first_sym);
            m_next_code++;
            if (m_next_code >= m_width_limit && m_width_limit < TABLE_SIZE) begin
               m_width_limit *= 2;
               m_width++;
            end
         end
         m_prev_code = code;
         m_stack_count--;
         sym = m_stack[m_stack_count];
         return STAT_SYMBOL;
      end
      return STAT_ERROR;
   endfunction

   function automatic result_beat_type predict_result(mode_type mode, logic [7:0] b);
      result_beat_type r;
      logic [7:0]      sym;
      r.symbol = 8'd0;
      case (mode)
         MODE_PUSH:  r.status = model_push(b);
         MODE_PULL: begin
            r.status = model_pull(sym);
            if (r.status == STAT_SYMBOL) r.symbol = sym;
         end
         MODE_START: begin
            model_start();
            r.status = STAT_ACCEPTED;
         end
         default:    r.status = STAT_ERROR;
      endcase
      return r;
   endfunction

   // Command driver: new beats go out on the falling edge.
   always @(negedge clock) begin
      cmd_beat_type b;
      if (!reset && (!req_tvalid || cmd_taken)) begin
         if (cmd_queue.size() > 0 && cmd_queue[0].hold) begin
            if (expected_results.size() == 0) b = cmd_queue.pop_front();
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            b = cmd_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= b.mode;
            req_tdata  <= b.data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      cmd_taken = 1'b0;
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Acceptance, prediction and result checking on the rising edge.
   always @(posedge clock) begin
      result_beat_type exp_beat;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("gif_lzw_decoder_unit regression: fail");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_result(mode_type'(req_tuser), req_tdata));
            cmds_sent++;
            cmd_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: status %0d symbol %0d",
                           rsp_tuser, rsp_tdata);
            end else begin
               exp_beat = expected_results.pop_front();
               if (exp_beat.status == STAT_SYMBOL) symbols_seen++;
               if (rsp_tuser !== exp_beat.status || rsp_tdata !== exp_beat.symbol) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected status %0d symbol %0d, got %0d %0d",
                              results_seen, exp_beat.status, exp_beat.symbol,
                              rsp_tuser, rsp_tdata);
               end
            end
         end
      end
   end

   task automatic add_cmd(mode_type m, logic [7:0] d);
      cmd_beat_type b;
      b.mode = m;
      b.data = d;
      b.hold = 1'b0;
      cmd_queue.push_back(b);
   endtask

   task automatic add_hold();
      cmd_beat_type b;
      b.mode = MODE_PULL;
      b.data = 8'd0;
      b.hold = 1'b1;
      cmd_queue.push_back(b);
   endtask

   // Stream builder state: code bits, where each code ends, and the pulls it needs.
   bit         gen_bits[$];
   int         gen_code_end[$];
   int         gen_code_pulls[$];
   logic [7:0] gen_payload[$];
   int         gen_idx;
   int         gen_block_left;
   int         gen_str_len[0:TABLE_SIZE-1];

   task automatic emit_code(int c, int w, int pulls);
      for (int i = 0; i < w; i++) gen_bits.push_back(c[i]);
      gen_code_end.push_back(gen_bits.size());
      gen_code_pulls.push_back(pulls);
   endtask

   // Sends the next payload byte, opening a sub-block with its length byte when needed.
   task automatic feed_byte();
      int len;
      if (gen_block_left == 0) begin
         len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 255);
         if (len > gen_payload.size() - gen_idx) len = gen_payload.size() - gen_idx;
         add_cmd(MODE_PUSH, 8'(len));
         gen_block_left = len;
      end
      add_cmd(MODE_PUSH, gen_payload[gen_idx]);
      gen_idx++;
      gen_block_left--;
   endtask

   // Builds a code stream, with invalid codes at bad_pct, for the root size cfg_val saturates to,
   // then schedules pushes just ahead of the pulls that consume each code.
   task automatic build_image(int cfg_val, int ncodes, int kw_pct, int maxlen,
                              int clr_pct, int bad_pct);
      int root;
      int clr;
      int width;
      int nf;
      int lim;
      int prev;
      int c;
      int v;
      int len;
      bit first;
      logic [7:0] by;
      root = cfg_val;
      if (root < MIN_ROOT) root = MIN_ROOT;
      if (root > MAX_ROOT) root = MAX_ROOT;
      clr = 1 << root;
      width = root + 1;
      nf = clr + 2;
      lim = 2 * clr;
      prev = 0;
      first = 1'b1;
      gen_bits.delete();
      gen_code_end.delete();
      gen_code_pulls.delete();
      gen_payload.delete();
      for (int i = 0; i < clr; i++) gen_str_len[i] = 1;
      images_built++;
      add_cmd(MODE_START, 8'($urandom));
      repeat ($urandom_range(0, 2)) emit_code(clr, width, 0);
      for (int k = 0; k < ncodes; k++) begin
         if (!first && $urandom_range(0, 99) < clr_pct) begin
            emit_code(clr, width, 0);
            width = root + 1;
            nf = clr + 2;
            lim = 2 * clr;
            first = 1'b1;
            continue;
         end
         if ($urandom_range(0, 99) < bad_pct) begin
            if (first) emit_code(clr + 2, width, 1);
            else if (nf + 1 < (1 << width)) emit_code(nf + 1, width, 1);
            continue;
         end
         if (first) begin
            c = $urandom_range(0, clr - 1);
            emit_code(c, width, 1);
            first = 1'b0;
            prev = c;
            continue;
         end
         if (nf < TABLE_SIZE && $urandom_range(0, 99) < kw_pct && gen_str_len[prev] < maxlen)
         begin
            c = nf;
            len = gen_str_len[prev] + 1;
         end else begin
            c = $urandom_range(0, clr - 1);
            if (nf > clr + 2 && $urandom_range(0, 1) == 1) begin
               v = $urandom_range(clr + 2, nf - 1);
               if (gen_str_len[v] <= maxlen) c = v;
            end
            len = gen_str_len[c];
         end
         emit_code(c, width, len);
         if (nf < TABLE_SIZE) begin
            gen_str_len[nf] = gen_str_len[prev] + 1;
            nf++;
            if (nf >= lim && lim < TABLE_SIZE) begin
               lim *= 2;
               width++;
            end
         end
         prev = c;
      end
      emit_code(clr + 1, width, 1);
      for (int i = 0; i < (gen_bits.size() + 7) / 8; i++) begin
         for (int j = 0; j < 8; j++)
            by[j] = (8 * i + j < gen_bits.size()) ? gen_bits[8 * i + j] : 1'b0;
         gen_payload.push_back(by);
      end
      gen_idx = 0;
      gen_block_left = 0;
      for (int k = 0; k < gen_code_end.size(); k++) begin
         if ($urandom_range(0, 99) < 5) add_cmd(MODE_PULL, 8'($urandom));
         while (gen_idx * 8 < gen_code_end[k]) feed_byte();
         repeat (gen_code_pulls[k]) add_cmd(MODE_PULL, 8'($urandom));
      end
      while (gen_idx < gen_payload.size()) feed_byte();
      add_cmd(MODE_PUSH, 8'd0);
      repeat (2) add_cmd(MODE_PULL, 8'($urandom));
   endtask

   task automatic add_noise(int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 45) add_cmd(MODE_PUSH, 8'($urandom));
         else if (r < 85) add_cmd(MODE_PULL, 8'($urandom));
         else if (r < 95) add_cmd(MODE_START, 8'($urandom));
         else add_cmd(MODE_BAD, 8'($urandom));
      end
   endtask

   task automatic wait_idle();
      while (cmd_queue.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_MIN_CODE_SIZE);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cfg_min_size = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      cycle_count = 0;
      mismatches  = 0;
      cfg_min_size = 4'(MIN_CODE_RESET);
      model_start();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: undefined command, pull with no data, a full bit reservoir,
      // end of data by a zero-length block, and pushes after the end.
      add_cmd(MODE_BAD, 8'hFF);
      add_cmd(MODE_PULL, 8'h00);
      add_cmd(MODE_PUSH, 8'd6);
      add_cmd(MODE_PUSH, 8'h00);
      add_cmd(MODE_PUSH, 8'hFF);
      add_cmd(MODE_PUSH, 8'h55);
      add_cmd(MODE_PUSH, 8'hAA);
      add_cmd(MODE_PUSH, 8'hFF);
      add_cmd(MODE_PULL, 8'hFF);
      add_cmd(MODE_START, 8'h00);
      add_cmd(MODE_PUSH, 8'd0);
      add_cmd(MODE_PULL, 8'h00);
      add_cmd(MODE_PULL, 8'h00);
      add_cmd(MODE_PUSH, 8'hFF);
      build_image(MIN_CODE_RESET, 12, 30, 6, 0, 10);
      wait_idle();

      csr_write(4'd2);
      idle_pct = 73;
      build_image(2, 40, 30, 10, 4, 3);
      build_image(2, 30, 40, 20, 0, 3);
      wait_idle();

      csr_write(4'd5);
      idle_pct = 0;
      stall_pct = 73;
      build_image(5, 40, 30, 10, 4, 3);
      build_image(5, 30, 20, 8, 2, 3);
      wait_idle();

      csr_write(4'd8);
      idle_pct = 26;
      stall_pct = 26;
      build_image(8, 40, 30, 10, 3, 3);
      add_noise(80);
      wait_idle();

      // Out-of-range root sizes saturate to the nearest legal size.
      csr_write(4'd0);
      idle_pct = 0;
      stall_pct = 0;
      build_image(0, 20, 30, 8, 0, 0);
      wait_idle();

      csr_write(4'd15);
      idle_pct = 26;
      stall_pct = 26;
      build_image(15, 30, 30, 10, 3, 3);
      add_hold();
      add_noise(40);
      build_image(15, 30, 30, 10, 3, 3);
      wait_idle();

      csr_write(4'd3);
      idle_pct = 10;
      stall_pct = 50;
      build_image(3, 40, 30, 12, 4, 3);
      wait_idle();

      $display("run covered %0d command beats and %0d result beats (%0d symbols)",
               cmds_sent, results_seen, symbols_seen);
      $display("%0d images over root sizes 2 to 8, with saturated sizes and random commands",
               images_built);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("gif_lzw_decoder_unit regression: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
         $display("gif_lzw_decoder_unit regression: fail");
      end
      $finish;
   end

endmodule
